// ===== src/sabm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabm_pkg: shared types and constants of the semaphore arm animator
// Opcodes, pull phases, per-channel state layout, pipeline stage records
// and the constant-divide helpers.
// ----------------------------------------------------------------------------
package sabm_pkg;

  // default channel count
  localparam int CHANNELS_DEF = 16;

  // stream widths
  localparam int S_DATA_W = 80;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 16;

  // opcodes, the remaining code leaves the channel alone
  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PULL    = 2'd2;

  // motion constants
  localparam int GRAVITY = 3;
  localparam int NEAR    = 3;

  // divide by 30 on a 16-bit magnitude: multiply by ceil(2^20 / 30)
  localparam logic [15:0] DIV30_MUL   = 16'd34953;
  localparam int          DIV30_SHIFT = 20;
  // divide by 25 on a 20-bit magnitude: multiply by ceil(2^25 / 25)
  localparam logic [20:0] DIV25_MUL   = 21'd1342178;
  localparam int          DIV25_SHIFT = 25;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_PAUSE,
    PH_SECOND,
    PH_DONE
  } phase_t;

  // per-channel state, speed doubles as the pause counter
  typedef struct packed {
    phase_t      phase;
    logic [15:0] speed;
    logic [7:0]  pos;
  } arm_state_t;

  // one accepted request
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] ch;
    logic       in_range;
    logic [7:0] tgt;
    logic [7:0] start;
    logic [7:0] lower;
    logic [7:0] upper;
    logic [6:0] coeff;
    logic [7:0] rate;
    logic [7:0] pause;
    logic [7:0] travel_start;
    logic [7:0] travel_end;
  } item_t;

  // after the first compute stage
  typedef struct packed {
    logic        [1:0]  op;
    logic        [3:0]  ch;
    logic               in_range;
    logic               rev;
    logic               settled;
    arm_state_t         cur;
    arm_state_t         alt;
    logic               alt_fin;
    logic        [7:0]  lower;
    logic        [11:0] q0;
    logic        [11:0] q1;
    logic        [15:0] spd_g;
    logic        [21:0] prod;
    logic               bneg;
  } s1_t;

  // after the second compute stage
  typedef struct packed {
    logic        [1:0]  op;
    logic        [3:0]  ch;
    logic               in_range;
    logic               rev;
    logic               settled;
    arm_state_t         cur;
    arm_state_t         alt;
    logic               alt_fin;
    logic        [7:0]  lower;
    logic               hit;
    logic        [15:0] quot;
    logic               bneg;
    arm_state_t         grav;
  } s2_t;

  // unsigned a / 30 for a below 2^16
  function automatic logic [10:0] div30(input logic [15:0] a);
    logic [31:0] p;
    p = {16'b0, a} * {16'b0, DIV30_MUL};
    return p[DIV30_SHIFT+10:DIV30_SHIFT];
  endfunction

  // signed 16-bit v / 30 truncated toward zero, two's complement result
  function automatic logic [11:0] sdiv30(input logic [15:0] v);
    logic [15:0] mag;
    logic [11:0] q;
    mag = v[15] ? (~v + 16'd1) : v;
    q   = {1'b0, div30(mag)};
    return v[15] ? (~q + 12'd1) : q;
  endfunction

endpackage

// ===== src/sabm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabm_ram: generic single-write single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sabm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sabm_stage_a.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabm_stage_a: first compute stage
// Settle test, speed quotients, bounce product, and the full init and pull
// results.
// ----------------------------------------------------------------------------
module sabm_stage_a import sabm_pkg::*; (
  input  item_t      item,
  input  arm_state_t cur,
  output s1_t        s1
);

  logic        rev;
  logic        near_pos;
  logic        spd_small;
  logic [15:0] spd_g;
  logic [15:0] mag;
  logic [22:0] prod_w;
  logic [7:0]  mid;
  logic [7:0]  step;
  logic [9:0]  tgt_m3;
  logic        mid_hit;
  logic        tgt_hit;
  arm_state_t  alt;
  logic        alt_fin;

  assign rev = item.lower > item.upper;

  // release settle test: position near the target and speed near rest
  assign near_pos  = ({1'b0, cur.pos} <= ({1'b0, item.tgt} + 9'(NEAR))) &&
                     ({1'b0, item.tgt} <= ({1'b0, cur.pos} + 9'(NEAR)));
  assign spd_small = (cur.speed <= 16'(NEAR)) || (cur.speed >= 16'(-NEAR));

  // gravity speed and the bounce product magnitude
  assign spd_g  = cur.speed + 16'(GRAVITY);
  assign mag    = cur.speed[15] ? (~cur.speed + 16'd1) : cur.speed;
  assign prod_w = {7'b0, mag} * {16'b0, item.coeff};

  // pull stepping
  assign mid     = {1'b0, item.travel_end[7:1]} + {1'b0, item.travel_start[7:1]};
  assign step    = rev ? (cur.pos - item.rate) : (cur.pos + item.rate);
  assign tgt_m3  = {2'b0, item.tgt} - 10'(NEAR);
  assign mid_hit = rev ? (step <= mid) : (step >= mid);
  assign tgt_hit = rev ? ($signed({2'b0, step}) <= $signed(tgt_m3))
                       : ($signed({2'b0, step}) >= $signed(tgt_m3));

  // result of every opcode other than release
  always_comb begin
    alt     = cur;
    alt_fin = 1'b0;
    case (item.op)
      OP_INIT: begin
        alt.phase = PH_FIRST;
        alt.speed = '0;
        alt.pos   = item.start;
      end
      OP_PULL: begin
        case (cur.phase)
          PH_FIRST: begin
            alt.pos = step;
            if (mid_hit) begin
              alt.phase = PH_PAUSE;
              alt.speed = {8'b0, item.pause};
            end
          end
          PH_PAUSE: begin
            if (cur.speed == '0) begin
              alt.phase = PH_SECOND;
            end
            alt.speed = cur.speed - 16'd1;
          end
          PH_SECOND: begin
            alt.pos = step;
            if (tgt_hit) begin
              alt.phase = PH_DONE;
              alt_fin   = 1'b1;
            end
          end
          default: begin
            alt = cur;
          end
        endcase
      end
      default: begin
        alt = cur;
      end
    endcase
  end

  // stage record
  always_comb begin
    s1.op       = item.op;
    s1.ch       = item.ch;
    s1.in_range = item.in_range;
    s1.rev      = rev;
    s1.settled  = near_pos && spd_small;
    s1.cur      = cur;
    s1.alt      = alt;
    s1.alt_fin  = alt_fin;
    s1.lower    = item.lower;
    s1.q0       = sdiv30(cur.speed);
    s1.q1       = sdiv30(spd_g);
    s1.spd_g    = spd_g;
    s1.prod     = prod_w[21:0];
    s1.bneg     = ~cur.speed[15];
  end

endmodule

// ===== src/sabm_stage_b.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabm_stage_b: second compute stage
// Lower stop crossing test, gravity step and the percent divide of the
// bounce speed.
// ----------------------------------------------------------------------------
module sabm_stage_b import sabm_pkg::*; (
  input  s1_t s1,
  output s2_t s2
);

  logic [12:0] lower13;
  logic [12:0] pos13;
  logic [12:0] q0_13;
  logic        hit;
  logic [19:0] p4;
  logic [40:0] qprod;
  logic [11:0] qp1;
  arm_state_t  grav;

  // crossing test against the lower stop, signed 13-bit
  assign lower13 = {5'b0, s1.lower};
  assign pos13   = {5'b0, s1.cur.pos};
  assign q0_13   = {s1.q0[11], s1.q0};
  assign hit     = s1.rev ? ($signed(pos13) > $signed(lower13 - q0_13))
                          : ($signed(pos13) < $signed(lower13 + q0_13));

  // magnitude / 100 as (magnitude / 4) / 25
  assign p4    = s1.prod[21:2];
  assign qprod = {21'b0, p4} * {20'b0, DIV25_MUL};

  // gravity step, position wraps at 8 bits
  assign qp1 = s1.q1 + 12'd1;
  always_comb begin
    grav       = s1.cur;
    grav.speed = s1.spd_g;
    grav.pos   = s1.rev ? (s1.cur.pos + qp1[7:0]) : (s1.cur.pos - qp1[7:0]);
  end

  always_comb begin
    s2.op       = s1.op;
    s2.ch       = s1.ch;
    s2.in_range = s1.in_range;
    s2.rev      = s1.rev;
    s2.settled  = s1.settled;
    s2.cur      = s1.cur;
    s2.alt      = s1.alt;
    s2.alt_fin  = s1.alt_fin;
    s2.lower    = s1.lower;
    s2.hit      = hit;
    s2.quot     = qprod[DIV25_SHIFT+15:DIV25_SHIFT];
    s2.bneg     = s1.bneg;
    s2.grav     = grav;
  end

endmodule

// ===== src/sabm_stage_c.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabm_stage_c: final compute stage
// Bounce speed and position, release selection and the channel's new state.
// ----------------------------------------------------------------------------
module sabm_stage_c import sabm_pkg::*; (
  input  s2_t        s2,
  output arm_state_t nxt,
  output logic       fin
);

  logic [16:0] s17;
  logic [16:0] w17;
  logic [15:0] w;
  logic [11:0] q2;
  logic [8:0]  base;
  logic [7:0]  bpos;
  arm_state_t  rel;

  // signed bounce speed wrapped to 16 bits
  assign s17 = {1'b0, s2.quot};
  assign w17 = s2.bneg ? (~s17 + 17'd1) : s17;
  assign w   = w17[15:0];
  assign q2  = sdiv30(w);

  // reflect about the lower stop and apply the new speed
  assign base = {s2.lower, 1'b0} - {1'b0, s2.cur.pos};
  assign bpos = s2.rev ? (base[7:0] + q2[7:0]) : (base[7:0] - q2[7:0]);

  // release outcome
  always_comb begin
    if (s2.settled) begin
      rel = s2.cur;
    end else if (s2.hit) begin
      rel       = s2.cur;
      rel.speed = w;
      rel.pos   = bpos;
    end else begin
      rel = s2.grav;
    end
  end

  // opcode selection
  always_comb begin
    if (s2.op == OP_RELEASE) begin
      nxt = rel;
      fin = s2.settled;
    end else begin
      nxt = s2.alt;
      fin = s2.alt_fin;
    end
  end

endmodule

// ===== src/servo_arm_bounce_motion_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_arm_bounce_motion_top: semaphore arm servo animator
// Per-channel position, speed and pull phase with init, gravity/bounce and
// two-stage pull steps.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transfer: opcode in tuser, the channel
//   and the motion settings in tdata. m_axis returns one result per request
//   in request order: channel, position after the step and a finished flag.
//   The state is read at the accepting edge, then three compute stages
//   follow, the last one loading the result register shown on m_axis.
//   Requests for different channels are taken one per cycle while m_axis
//   is not holding the pipeline. A request for a channel that still has
//   a request in the pipeline waits until that one has written its state
//   back, so a single channel takes no new request until its last one is
//   through the per-channel state read, compute and write back loop.
//   Reset clears the per-channel valid bits, so every channel reads as
//   position 0, speed 0, first pull phase, and empties the pipeline; no
//   clearing pass is needed.
//   When m_axis_tready is low with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module servo_arm_bounce_motion_top import sabm_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: channel[3:0], target_position[11:4], start_position[19:12],
  // lower_stop[27:20], upper_stop[35:28], bounce_percent[42:36],
  // pull_rate[50:43], pause_steps[58:51], travel_start[66:59],
  // travel_end[74:67], zero[79:75]
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [S_USER_W-1:0] s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: out_channel[3:0], position[11:4], finished[12], zero[15:13]
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ST_W   = $bits(arm_state_t);

  item_t             item_in;
  logic              advance;
  logic              hazard;
  logic              accept;
  logic              v0;
  logic              v1;
  logic              v2;
  logic              out_valid;
  item_t             s0;
  s1_t               s1;
  s2_t               s2;
  s1_t               s1_next;
  s2_t               s2_next;
  logic              rd_ok;
  logic [CHANNELS-1:0] ent_valid;
  logic [ST_W-1:0]   rd_data;
  arm_state_t        cur;
  arm_state_t        nxt;
  logic              fin;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic              wr_en;
  logic [3:0]        out_ch;
  logic [7:0]        out_pos;
  logic              out_fin;

  // request unpacking
  always_comb begin
    item_in.op           = s_axis_tuser[1:0];
    item_in.ch           = s_axis_tdata[3:0];
    item_in.in_range     = 32'(s_axis_tdata[3:0]) < 32'(CHANNELS);
    item_in.tgt          = s_axis_tdata[11:4];
    item_in.start        = s_axis_tdata[19:12];
    item_in.lower        = s_axis_tdata[27:20];
    item_in.upper        = s_axis_tdata[35:28];
    item_in.coeff        = s_axis_tdata[42:36];
    item_in.rate         = s_axis_tdata[50:43];
    item_in.pause        = s_axis_tdata[58:51];
    item_in.travel_start = s_axis_tdata[66:59];
    item_in.travel_end   = s_axis_tdata[74:67];
  end

  // pipeline moves as one when the result slot is free or being taken
  assign advance = !out_valid || m_axis_tready;
  assign hazard  = (v0 && (s0.ch == item_in.ch)) ||
                   (v1 && (s1.ch == item_in.ch)) ||
                   (v2 && (s2.ch == item_in.ch));
  assign s_axis_tready = advance && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // channel state store
  assign raddr = ADDR_W'(item_in.ch);
  assign waddr = ADDR_W'(s2.ch);
  assign wr_en = advance && v2 && s2.in_range;

  sabm_ram #(
    .WIDTH(ST_W),
    .DEPTH(CHANNELS)
  ) u_state_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(waddr),
    .wdata(nxt),
    .re   (accept),
    .raddr(raddr),
    .rdata(rd_data)
  );

  // never-written channels read as the reset state
  assign cur = rd_ok ? arm_state_t'(rd_data) : arm_state_t'('0);

  sabm_stage_a u_stage_a (
    .item(s0),
    .cur (cur),
    .s1  (s1_next)
  );

  sabm_stage_b u_stage_b (
    .s1(s1),
    .s2(s2_next)
  );

  sabm_stage_c u_stage_c (
    .s2 (s2),
    .nxt(nxt),
    .fin(fin)
  );

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v0        <= accept;
      v1        <= v0;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[waddr] <= 1'b1;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s0      <= item_in;
      rd_ok   <= item_in.in_range && ent_valid[raddr];
      s1      <= s1_next;
      s2      <= s2_next;
      out_ch  <= s2.ch;
      out_pos <= s2.in_range ? nxt.pos : 8'd0;
      out_fin <= s2.in_range && fin;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b0, out_fin, out_pos, out_ch};

  // no two requests for one channel are in flight together
  a_one_per_channel: assert property (@(posedge clk) disable iff (rst)
    !((v0 && v1 && (s0.ch == s1.ch)) || (v0 && v2 && (s0.ch == s2.ch)) ||
      (v1 && v2 && (s1.ch == s2.ch))))
    else $error("two in-flight requests share a channel");

  // a state read never collides with the write of the same entry
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && accept && item_in.in_range) |-> (waddr != raddr))
    else $error("state read and write hit the same entry");

  // a channel outside the range reports position 0, not finished
  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (32'(out_ch) >= 32'(CHANNELS))) |-> ((out_pos == 8'd0) && !out_fin))
    else $error("out of range channel gave a position");

  // a written entry is marked valid on the next cycle
  a_valid_after_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> ent_valid[$past(waddr)])
    else $error("written entry not marked valid");

endmodule

// ===== tb/tb_servo_arm_bounce_motion_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_arm_bounce_motion_top: self-checking bench for the arm animator
// A queue of requests feeds a clocked driver with random gaps. A built-in
// model of each channel's position, speed and pull phase predicts every
// result. A clocked monitor under random back-pressure compares each result
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_servo_arm_bounce_motion_top;
  import sabm_pkg::*;

  localparam int         LIMIT     = 200000;
  localparam int         SPEED_DIV = 30;
  localparam int         PERCENT   = 100;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef struct {
    logic [1:0] op;
    logic [3:0] ch;
    logic [7:0] tgt;
    logic [7:0] start;
    logic [7:0] lower;
    logic [7:0] upper;
    logic [6:0] coeff;
    logic [7:0] rate;
    logic [7:0] pause;
    logic [7:0] ts;
    logic [7:0] te;
    bit         drain;
  } servo_req_t;

  typedef struct {
    logic [3:0] ch;
    logic [7:0] pos;
    logic       fin;
  } motion_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [S_USER_W-1:0] s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  // channel state as predicted
  logic [7:0]  arm_pos   [16];
  logic [15:0] arm_speed [16];
  phase_t      arm_phase [16];

  servo_req_t     servo_requests[$];
  motion_result_t expected_positions[$];
  int             n_queued   = 0;
  int             n_accepted = 0;
  int             errors     = 0;
  int             cycle_cnt  = 0;
  bit             req_taken  = 0;
  bit             res_taken  = 0;
  bit             tx_idle    = 1;
  bit             rx_idle    = 1;
  int             gap_left   = 0;
  int             stall_left = 0;

  servo_arm_bounce_motion_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // one step of a channel: update the predicted state, return the result
  function automatic motion_result_t arm_step(input servo_req_t r);
    motion_result_t res;
    int             pos, spd, nspd, tgt, lower, upper, coeff;
    logic [7:0]     p, mid;
    bit             rev;
    res.ch  = r.ch;
    res.fin = 1'b0;
    case (r.op)
      OP_INIT: begin
        arm_phase[r.ch] = PH_FIRST;
        arm_speed[r.ch] = '0;
        arm_pos[r.ch]   = r.start;
      end
      OP_RELEASE: begin
        pos   = int'(arm_pos[r.ch]);
        tgt   = int'(r.tgt);
        lower = int'(r.lower);
        upper = int'(r.upper);
        coeff = int'(r.coeff);
        spd   = int'($signed(arm_speed[r.ch]));
        rev   = lower > upper;
        if (pos <= tgt + NEAR && pos >= tgt - NEAR && spd <= NEAR && spd >= -NEAR) begin
          // settled at the target, nothing moves
          res.fin = 1'b1;
        end else if (rev ? (pos > lower - spd / SPEED_DIV)
                         : (pos < lower + spd / SPEED_DIV)) begin
          // bounce off the lower stop with reversed, damped speed
          nspd            = (-spd * coeff) / PERCENT;
          arm_speed[r.ch] = nspd[15:0];
          spd             = int'($signed(arm_speed[r.ch]));
          pos = rev ? lower + (lower - pos) + spd / SPEED_DIV
                    : lower - (pos - lower) - spd / SPEED_DIV;
          arm_pos[r.ch] = pos[7:0];
        end else begin
          // free fall under gravity
          nspd            = spd + GRAVITY;
          arm_speed[r.ch] = nspd[15:0];
          spd             = int'($signed(arm_speed[r.ch]));
          pos = rev ? pos + (spd / SPEED_DIV + 1) : pos - (spd / SPEED_DIV + 1);
          arm_pos[r.ch] = pos[7:0];
        end
      end
      OP_PULL: begin
        rev = r.lower > r.upper;
        mid = (r.te >> 1) + (r.ts >> 1);
        case (arm_phase[r.ch])
          PH_FIRST: begin
            p = rev ? arm_pos[r.ch] - r.rate : arm_pos[r.ch] + r.rate;
            arm_pos[r.ch] = p;
            if (rev ? (p <= mid) : (p >= mid)) begin
              arm_phase[r.ch] = PH_PAUSE;
              arm_speed[r.ch] = {8'd0, r.pause};
            end
          end
          PH_PAUSE: begin
            if (arm_speed[r.ch] == 16'd0) arm_phase[r.ch] = PH_SECOND;
            arm_speed[r.ch] = arm_speed[r.ch] - 16'd1;
          end
          PH_SECOND: begin
            p = rev ? arm_pos[r.ch] - r.rate : arm_pos[r.ch] + r.rate;
            arm_pos[r.ch] = p;
            // target compared without wrap
            if (rev ? (int'(p) <= int'(r.tgt) - NEAR) : (int'(p) >= int'(r.tgt) - NEAR)) begin
              arm_phase[r.ch] = PH_DONE;
              res.fin = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.pos = arm_pos[r.ch];
    return res;
  endfunction

  function automatic servo_req_t rand_req();
    servo_req_t r;
    r.op    = 2'($urandom_range(0, 3));
    r.ch    = 4'($urandom_range(0, 15));
    r.tgt   = 8'($urandom);
    r.start = 8'($urandom);
    r.lower = 8'($urandom);
    r.upper = 8'($urandom);
    r.coeff = 7'($urandom_range(0, 127));
    r.rate  = 8'($urandom);
    r.pause = 8'($urandom);
    r.ts    = 8'($urandom);
    r.te    = 8'($urandom);
    r.drain = 0;
    return r;
  endfunction

  task automatic add_req(input logic [1:0] op, input logic [3:0] ch,
                         input logic [7:0] tgt, start, lower, upper,
                         input logic [6:0] coeff, input logic [7:0] rate, pause, ts, te);
    servo_req_t r;
    r = '{op, ch, tgt, start, lower, upper, coeff, rate, pause, ts, te, 0};
    servo_requests.push_back(r);
  endtask

  // stimulus, reset and end of run
  initial begin
    servo_req_t chan_plan   [16];
    bit         chan_pull   [16];
    bit         chan_primed [16];
    servo_req_t r;
    int         ch, roll;
    for (int i = 0; i < 16; i++) begin
      arm_pos[i]     = '0;
      arm_speed[i]   = '0;
      arm_phase[i]   = PH_FIRST;
      chan_primed[i] = 0;
    end

    // directed: field extremes, unused opcode, settled arm
    add_req(OP_INIT, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_req(OP_INIT, 4'd15, 8'd255, 8'd255, 8'd255, 8'd255, 7'd127, 8'd255, 8'd255,
            8'd255, 8'd255);
    add_req(OP_NOP, 4'd15, 8'd255, 8'd255, 8'd255, 8'd255, 7'd127, 8'd255, 8'd255,
            8'd255, 8'd255);
    add_req(OP_RELEASE, 4'd0, 8'd0, 8'd0, 8'd0, 8'd255, 7'd50, 8'd0, 8'd0, 8'd0, 8'd0);
    // release near the lower stop with more than full speed kept on a bounce; the arm settles at the target first
    add_req(OP_INIT, 4'd1, 8'd20, 8'd24, 8'd20, 8'd200, 7'd127, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (6)
      add_req(OP_RELEASE, 4'd1, 8'd20, 8'd24, 8'd20, 8'd200, 7'd127, 8'd0, 8'd0, 8'd0,
              8'd0);
    // reversed release
    add_req(OP_INIT, 4'd2, 8'd100, 8'd195, 8'd200, 8'd10, 7'd50, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (3)
      add_req(OP_RELEASE, 4'd2, 8'd100, 8'd195, 8'd200, 8'd10, 7'd50, 8'd0, 8'd0, 8'd0,
              8'd0);
    // full pull with zero pause and a target below the near band
    add_req(OP_INIT, 4'd3, 8'd2, 8'd0, 8'd0, 8'd255, 7'd0, 8'd255, 8'd0, 8'd255, 8'd255);
    repeat (4)
      add_req(OP_PULL, 4'd3, 8'd2, 8'd0, 8'd0, 8'd255, 7'd0, 8'd255, 8'd0, 8'd255, 8'd255);
    // reversed pull with a one-step pause
    add_req(OP_INIT, 4'd4, 8'd255, 8'd255, 8'd255, 8'd0, 7'd0, 8'd255, 8'd1, 8'd0, 8'd0);
    repeat (4)
      add_req(OP_PULL, 4'd4, 8'd255, 8'd255, 8'd255, 8'd0, 7'd0, 8'd255, 8'd1, 8'd0, 8'd0);

    // random: per-channel motion sequences with some noise
    for (int i = 0; i < 750; i++) begin
      ch   = $urandom_range(0, 15);
      roll = $urandom_range(0, 99);
      if (roll < 8 || !chan_primed[ch]) begin
        r    = rand_req();
        r.op = OP_INIT;
        r.ch = 4'(ch);
        chan_pull[ch] = 1'($urandom_range(0, 1));
        if (chan_pull[ch]) begin
          if ($urandom_range(0, 3) != 0) r.rate = 8'($urandom_range(1, 40));
          if ($urandom_range(0, 3) != 0) r.pause = 8'($urandom_range(0, 6));
        end else begin
          if ($urandom_range(0, 3) != 0) r.tgt = r.lower;
          if ($urandom_range(0, 3) != 0) r.coeff = 7'($urandom_range(20, 95));
        end
        chan_plan[ch]   = r;
        chan_primed[ch] = 1;
      end else if (roll < 96) begin
        r    = chan_plan[ch];
        // mostly the channel's own motion, sometimes the other one
        r.op = ((roll < 92) ^ chan_pull[ch]) ? OP_RELEASE : OP_PULL;
      end else begin
        r = rand_req();
      end
      r.drain = (i == 0 || i == 375);
      servo_requests.push_back(r);
    end
    n_queued = servo_requests.size();

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (n_accepted != n_queued) @(posedge clk);
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // request driver
  always @(negedge clk) begin
    servo_req_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !req_taken)) begin
      if (req_taken) begin
        req_taken = 0;
        gap_left  = tx_idle ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (servo_requests.size() != 0 &&
                   !(servo_requests[0].drain && expected_positions.size() != 0)) begin
        r = servo_requests.pop_front();
        s_axis_tdata  <= {5'd0, r.te, r.ts, r.pause, r.rate, r.coeff, r.upper, r.lower,
                          r.start, r.tgt, r.ch};
        s_axis_tuser  <= r.op;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (res_taken) begin
      res_taken  = 0;
      stall_left = rx_idle ? $urandom_range(0, 19) : 0;
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // accepted requests feed the prediction, results are checked in order
  always @(posedge clk) begin
    servo_req_t     r;
    motion_result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        r.op    = s_axis_tuser;
        r.ch    = s_axis_tdata[3:0];
        r.tgt   = s_axis_tdata[11:4];
        r.start = s_axis_tdata[19:12];
        r.lower = s_axis_tdata[27:20];
        r.upper = s_axis_tdata[35:28];
        r.coeff = s_axis_tdata[42:36];
        r.rate  = s_axis_tdata[50:43];
        r.pause = s_axis_tdata[58:51];
        r.ts    = s_axis_tdata[66:59];
        r.te    = s_axis_tdata[74:67];
        r.drain = 0;
        expected_positions.push_back(arm_step(r));
        n_accepted++;
        req_taken = 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        res_taken = 1;
        if (expected_positions.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want = expected_positions.pop_front();
          if (m_axis_tdata[3:0] !== want.ch) begin
            errors++;
            $display("%0t: out_channel expected %0d actual %0d", $time, want.ch,
                     m_axis_tdata[3:0]);
          end
          if (m_axis_tdata[11:4] !== want.pos) begin
            errors++;
            $display("%0t: position ch %0d expected %0d actual %0d", $time, want.ch,
                     want.pos, m_axis_tdata[11:4]);
          end
          if (m_axis_tdata[12] !== want.fin) begin
            errors++;
            $display("%0t: finished ch %0d expected %0d actual %0d", $time, want.ch,
                     want.fin, m_axis_tdata[12]);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
